[sv/wea_pkg.sv]
// ----------------------------------------------------------------------------
// wea_pkg
// Shared types and constants for the sliding-window extreme-average block.
// ----------------------------------------------------------------------------
`default_nettype none

package wea_pkg;

   localparam int WINDOW_LENGTH = 100;
   localparam int EXTREME_COUNT = 5;

   localparam int LEVEL_W  = 16;
   localparam int ADDR_W   = $clog2(WINDOW_LENGTH);
   localparam int CSR_IDX_W = 2;

   // chain sum and divide-by-count via reciprocal multiply
   localparam int SUM_W     = LEVEL_W + $clog2(EXTREME_COUNT);
   localparam int DIV_SHIFT = SUM_W + $clog2(EXTREME_COUNT);
   localparam int RECIP_W   = DIV_SHIFT + 1;
   localparam int PROD_W    = SUM_W + RECIP_W;
   localparam longint unsigned DIV_MULT_FULL =
      ((64'd1 << DIV_SHIFT) + 64'(EXTREME_COUNT) - 64'd1) / 64'(EXTREME_COUNT);
   localparam logic [RECIP_W-1:0] DIV_MULT = RECIP_W'(DIV_MULT_FULL);

   localparam logic [LEVEL_W-1:0] LOW_START_RESET  = 16'd38400;
   localparam logic [LEVEL_W-1:0] HIGH_START_RESET = 16'd0;

   localparam logic [CSR_IDX_W-1:0] CSR_LOW_START  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_START = 2'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DIVIDE,
      ST_HOLD
   } state_type;

   // data handed from one cell to the next
   typedef struct packed {
      logic               valid;
      logic               last;
      logic [LEVEL_W-1:0] low;
      logic [LEVEL_W-1:0] high;
   } chain_link_type;

endpackage

`default_nettype wire

[sv/wea_ram.sv]
// ----------------------------------------------------------------------------
// wea_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module wea_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[sv/wea_cell.sv]
// ----------------------------------------------------------------------------
// wea_cell
// One insertion cell: holds one lowest-set and one highest-set entry and
// passes the displaced values to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module wea_cell (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            load,
   input  wire logic [wea_pkg::LEVEL_W-1:0]     low_init,
   input  wire logic [wea_pkg::LEVEL_W-1:0]     high_init,
   input  wire wea_pkg::chain_link_type         link_in,
   output wea_pkg::chain_link_type              link_out,
   output logic      [wea_pkg::LEVEL_W-1:0]     low_value,
   output logic      [wea_pkg::LEVEL_W-1:0]     high_value
);

   logic [wea_pkg::LEVEL_W-1:0] low_ff, low_in;
   logic [wea_pkg::LEVEL_W-1:0] high_ff, high_in;
   wea_pkg::chain_link_type     link_ff, link_in_next;

   always_comb begin
      low_in             = low_ff;
      high_in            = high_ff;
      link_in_next       = link_ff;
      link_in_next.valid = link_in.valid;
      link_in_next.last  = link_in.valid & link_in.last;
      if (load) begin
         low_in  = low_init;
         high_in = high_init;
      end else if (link_in.valid) begin
         if (link_in.low <= low_ff) begin
            low_in            = link_in.low;
            link_in_next.low  = low_ff;
         end else begin
            link_in_next.low  = link_in.low;
         end
         if (link_in.high >= high_ff) begin
            high_in           = link_in.high;
            link_in_next.high = high_ff;
         end else begin
            link_in_next.high = link_in.high;
         end
      end
   end

   always_ff @(posedge clock) begin
      low_ff       <= low_in;
      high_ff      <= high_in;
      link_ff.low  <= link_in_next.low;
      link_ff.high <= link_in_next.high;
      if (reset) begin
         link_ff.valid <= 1'b0;
         link_ff.last  <= 1'b0;
      end else begin
         link_ff.valid <= link_in_next.valid;
         link_ff.last  <= link_in_next.last;
      end
   end

   assign link_out   = link_ff;
   assign low_value  = low_ff;
   assign high_value = high_ff;

endmodule

`default_nettype wire

[sv/window_extreme_average_core.sv]
// ----------------------------------------------------------------------------
// window_extreme_average_core
// Sliding window of levels; mean of the lowest and highest entries.
// ----------------------------------------------------------------------------
// the new sample is written into the window, then every entry is read through
// the insertion cells, one window read per cycle; the sums, quotients and result
// follow in their own registers. One item in flight; the next input transfer is
// taken the cycle after the result enters the output register
// reset clears the window to zero (per-entry valid bits), pointers, state and
// valid flags at once and restores the start thresholds; no clearing pass
`default_nettype none

module window_extreme_average_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [wea_pkg::LEVEL_W-1:0]       req_level_sample,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic      [wea_pkg::LEVEL_W-1:0]       rsp_low_average,
   output logic      [wea_pkg::LEVEL_W-1:0]       rsp_high_average,
   input  wire logic                              csr_write_enable,
   input  wire logic [wea_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [wea_pkg::LEVEL_W-1:0]       csr_write_data
);

   localparam int N = wea_pkg::WINDOW_LENGTH;
   localparam int K = wea_pkg::EXTREME_COUNT;
   localparam logic [wea_pkg::ADDR_W-1:0] LAST_ADDR = wea_pkg::ADDR_W'(N - 1);

   wea_pkg::state_type state_ff, state_in;

   logic [wea_pkg::LEVEL_W-1:0] low_start_ff, high_start_ff;
   logic [wea_pkg::ADDR_W-1:0]  wp_ff, wp_in;
   logic [wea_pkg::ADDR_W-1:0]  scan_ff, scan_in;
   logic [N-1:0]                entry_valid_ff;
   logic                        rd_valid_ff, rd_last_ff, rd_fill_ff;
   logic [wea_pkg::LEVEL_W-1:0] ram_rd_data;
   logic                        accept;
   logic                        load_chain;
   logic                        sum_en, div_en, rsp_load;

   logic [wea_pkg::SUM_W-1:0]   sum_low_ff, sum_high_ff, sum_low, sum_high;
   logic [wea_pkg::PROD_W-1:0]  prod_low, prod_high;
   logic [wea_pkg::LEVEL_W-1:0] quot_low_ff, quot_high_ff;
   logic                        rsp_valid_ff;
   logic [wea_pkg::LEVEL_W-1:0] rsp_low_ff, rsp_high_ff;

   wea_pkg::chain_link_type     link [K+1];
   logic [wea_pkg::LEVEL_W-1:0] low_value  [K];
   logic [wea_pkg::LEVEL_W-1:0] high_value [K];

   assign accept = req_valid & ~req_stall;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         low_start_ff  <= wea_pkg::LOW_START_RESET;
         high_start_ff <= wea_pkg::HIGH_START_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            wea_pkg::CSR_LOW_START:  low_start_ff  <= csr_write_data;
            wea_pkg::CSR_HIGH_START: high_start_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // window store
   wea_ram #(
      .WIDTH (wea_pkg::LEVEL_W),
      .DEPTH (N)
   ) u_window (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (wp_ff),
      .wr_data (req_level_sample),
      .rd_addr (scan_ff),
      .rd_data (ram_rd_data)
   );

   // control
   always_comb begin
      state_in   = state_ff;
      wp_in      = wp_ff;
      scan_in    = scan_ff;
      req_stall  = 1'b1;
      load_chain = 1'b0;
      sum_en     = 1'b0;
      div_en     = 1'b0;
      rsp_load   = 1'b0;
      unique case (state_ff)
         wea_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (accept) begin
               load_chain = 1'b1;
               scan_in    = '0;
               wp_in      = (wp_ff == LAST_ADDR) ? '0 : wp_ff + 1'b1;
               state_in   = wea_pkg::ST_SCAN;
            end
         end
         wea_pkg::ST_SCAN: begin
            if (scan_ff == LAST_ADDR) begin
               state_in = wea_pkg::ST_DRAIN;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         wea_pkg::ST_DRAIN: begin
            if (link[K].valid && link[K].last) begin
               sum_en   = 1'b1;
               state_in = wea_pkg::ST_DIVIDE;
            end
         end
         wea_pkg::ST_DIVIDE: begin
            div_en   = 1'b1;
            state_in = wea_pkg::ST_HOLD;
         end
         wea_pkg::ST_HOLD: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = wea_pkg::ST_IDLE;
            end
         end
         default: state_in = wea_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= wea_pkg::ST_IDLE;
         wp_ff          <= '0;
         scan_ff        <= '0;
         entry_valid_ff <= '0;
         rd_valid_ff    <= 1'b0;
         rd_last_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         wp_ff       <= wp_in;
         scan_ff     <= scan_in;
         rd_valid_ff <= (state_ff == wea_pkg::ST_SCAN);
         rd_last_ff  <= (state_ff == wea_pkg::ST_SCAN) && (scan_ff == LAST_ADDR);
         if (accept) begin
            entry_valid_ff[wp_ff] <= 1'b1;
         end
      end
   end

   // entries never written read as zero
   always_ff @(posedge clock) begin
      rd_fill_ff <= entry_valid_ff[scan_ff];
   end

   // insertion chain
   always_comb begin
      link[0].valid = rd_valid_ff;
      link[0].last  = rd_last_ff;
      link[0].low   = rd_fill_ff ? ram_rd_data : '0;
      link[0].high  = rd_fill_ff ? ram_rd_data : '0;
   end

   for (genvar k = 0; k < K; k++) begin : g_cell
      wea_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .load       (load_chain),
         .low_init   (low_start_ff),
         .high_init  (high_start_ff),
         .link_in    (link[k]),
         .link_out   (link[k+1]),
         .low_value  (low_value[k]),
         .high_value (high_value[k])
      );
   end

   // sums, then divide by reciprocal multiply
   always_comb begin
      sum_low  = '0;
      sum_high = '0;
      for (int k = 0; k < K; k++) begin
         sum_low  = sum_low  + wea_pkg::SUM_W'(low_value[k]);
         sum_high = sum_high + wea_pkg::SUM_W'(high_value[k]);
      end
   end

   assign prod_low  = wea_pkg::PROD_W'(sum_low_ff)  * wea_pkg::PROD_W'(wea_pkg::DIV_MULT);
   assign prod_high = wea_pkg::PROD_W'(sum_high_ff) * wea_pkg::PROD_W'(wea_pkg::DIV_MULT);

   always_ff @(posedge clock) begin
      if (sum_en) begin
         sum_low_ff  <= sum_low;
         sum_high_ff <= sum_high;
      end
      if (div_en) begin
         quot_low_ff  <= prod_low[wea_pkg::DIV_SHIFT +: wea_pkg::LEVEL_W];
         quot_high_ff <= prod_high[wea_pkg::DIV_SHIFT +: wea_pkg::LEVEL_W];
      end
      if (rsp_load) begin
         rsp_low_ff  <= quot_low_ff;
         rsp_high_ff <= quot_high_ff;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_low_average  = rsp_low_ff;
   assign rsp_high_average = rsp_high_ff;

endmodule

`default_nettype wire

[test/window_extreme_average_core_tb.sv]
// ----------------------------------------------------------------------------
// window_extreme_average_core_tb
// Self-checking bench for the sliding-window lowest/highest average core.
// Every sample transfer updates a local copy of the 100-entry window and both
// insertion chains. The bench checks each result transfer against the oldest
// predicted pair of averages. Directed samples and thresholds come first,
// then random traffic under three flow-control profiles.
// ----------------------------------------------------------------------------
`default_nettype none

module window_extreme_average_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLOCK_PERIOD = 20;
   localparam int LATENCY      = wea_pkg::WINDOW_LENGTH + wea_pkg::EXTREME_COUNT + 4;
   localparam int IDLE_LIMIT   = 5000;

   typedef struct packed {
      logic [wea_pkg::LEVEL_W-1:0] low_average;
      logic [wea_pkg::LEVEL_W-1:0] high_average;
   } averages_type;

   logic                          clock            = 1'b0;
   logic                          reset            = 1'b1;
   logic                          req_valid        = 1'b0;
   logic                          req_stall;
   logic [wea_pkg::LEVEL_W-1:0]   req_level_sample = '0;
   logic                          rsp_valid;
   logic                          rsp_stall        = 1'b0;
   logic [wea_pkg::LEVEL_W-1:0]   rsp_low_average;
   logic [wea_pkg::LEVEL_W-1:0]   rsp_high_average;
   logic                          csr_write_enable = 1'b0;
   logic [wea_pkg::CSR_IDX_W-1:0] csr_index        = '0;
   logic [wea_pkg::LEVEL_W-1:0]   csr_write_data   = '0;

   logic [wea_pkg::LEVEL_W-1:0]   level_window [wea_pkg::WINDOW_LENGTH] = '{default: '0};
   int                            next_slot      = 0;
   logic [wea_pkg::LEVEL_W-1:0]   low_start_reg  = wea_pkg::LOW_START_RESET;
   logic [wea_pkg::LEVEL_W-1:0]   high_start_reg = wea_pkg::HIGH_START_RESET;

   averages_type                  pending_averages [$];
   int                            send_idle_pct = 0;
   int                            recv_idle_pct = 0;
   int                            error_count   = 0;
   int                            checked_count = 0;
   int                            levels_sent   = 0;
   int                            setting_count = 0;
   int                            idle_cycles   = 0;

   window_extreme_average_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_level_sample (req_level_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_low_average  (rsp_low_average),
      .rsp_high_average (rsp_high_average),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // store the sample, then run both insertion chains over the whole window
   function automatic averages_type window_averages(
      input logic [wea_pkg::LEVEL_W-1:0] level);
      logic [wea_pkg::LEVEL_W-1:0] lowest  [wea_pkg::EXTREME_COUNT];
      logic [wea_pkg::LEVEL_W-1:0] highest [wea_pkg::EXTREME_COUNT];
      logic [wea_pkg::LEVEL_W-1:0] carry;
      logic [wea_pkg::LEVEL_W-1:0] held;
      int unsigned                 low_sum;
      int unsigned                 high_sum;
      averages_type                result;
      level_window[next_slot] = level;
      next_slot = (next_slot == wea_pkg::WINDOW_LENGTH - 1) ? 0 : next_slot + 1;
      for (int k = 0; k < wea_pkg::EXTREME_COUNT; k++) begin
         lowest[k]  = low_start_reg;
         highest[k] = high_start_reg;
      end
      for (int e = 0; e < wea_pkg::WINDOW_LENGTH; e++) begin
         carry = level_window[e];
         for (int k = 0; k < wea_pkg::EXTREME_COUNT; k++) begin
            if (carry <= lowest[k]) begin
               held      = lowest[k];
               lowest[k] = carry;
               carry     = held;
            end
         end
         carry = level_window[e];
         for (int k = 0; k < wea_pkg::EXTREME_COUNT; k++) begin
            if (carry >= highest[k]) begin
               held       = highest[k];
               highest[k] = carry;
               carry      = held;
            end
         end
      end
      low_sum  = 0;
      high_sum = 0;
      for (int k = 0; k < wea_pkg::EXTREME_COUNT; k++) begin
         low_sum  += lowest[k];
         high_sum += highest[k];
      end
      result.low_average  = wea_pkg::LEVEL_W'(low_sum / wea_pkg::EXTREME_COUNT);
      result.high_average = wea_pkg::LEVEL_W'(high_sum / wea_pkg::EXTREME_COUNT);
      return result;
   endfunction

   function automatic logic [wea_pkg::LEVEL_W-1:0] random_start();
      case ($urandom_range(3))
         0:       return '0;
         1:       return '1;
         default: return wea_pkg::LEVEL_W'($urandom);
      endcase
   endfunction

   // one sample transfer; entered and left at a falling edge
   task automatic send_level(input logic [wea_pkg::LEVEL_W-1:0] level);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_level_sample <= level;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_averages.push_back(window_averages(level));
      levels_sent++;
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_averages.size() != 0) @(negedge clock);
      repeat (LATENCY) @(negedge clock);
   endtask

   task automatic set_thresholds(input logic [wea_pkg::LEVEL_W-1:0] low_start,
                                 input logic [wea_pkg::LEVEL_W-1:0] high_start);
      drain_results();
      csr_write_enable <= 1'b1;
      csr_index        <= wea_pkg::CSR_LOW_START;
      csr_write_data   <= low_start;
      @(posedge clock);
      low_start_reg = low_start;
      @(negedge clock);
      csr_index      <= wea_pkg::CSR_HIGH_START;
      csr_write_data <= high_start;
      @(posedge clock);
      high_start_reg = high_start;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      setting_count++;
   endtask

   // partly filled window under the reset thresholds
   task automatic test_unfilled_window();
      logic [wea_pkg::LEVEL_W-1:0] levels [8];
      levels = '{16'h0000, 16'hFFFF, 16'd38400, 16'd38401, 16'd38399,
                 16'h0001, 16'h8000, 16'h7FFF};
      foreach (levels[i]) send_level(levels[i]);
   endtask

   // thresholds at the extremes and tied with the samples
   task automatic test_threshold_settings();
      set_thresholds(16'h0000, 16'hFFFF);
      send_level(16'h0000);
      send_level(16'hFFFF);
      send_level(16'h0001);
      send_level(16'hFFFE);
      set_thresholds(16'hFFFF, 16'h0000);
      send_level(16'hAAAA);
      send_level(16'h5555);
      send_level(16'hFFFF);
      set_thresholds(16'h1234, 16'h1234);
      send_level(16'h1234);
      send_level(16'h1233);
      send_level(16'h1235);
   endtask

   task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
                                      input int per_setting);
      int                          center;
      int                          value;
      logic [wea_pkg::LEVEL_W-1:0] level;
      drain_results();
      send_idle_pct = sender_pct;
      recv_idle_pct = receiver_pct;
      for (int round = 0; round < 2; round++) begin
         set_thresholds(random_start(), random_start());
         center = int'($urandom_range(65535));
         for (int n = 0; n < per_setting; n++) begin
            if (n == per_setting / 2) drain_results();
            case ($urandom_range(9))
               0, 1, 2, 3: value = int'($urandom_range(65535));
               4, 5, 6:    value = center + int'($urandom_range(15)) - 8;
               7, 8: begin
                  value = ($urandom_range(1) ? int'(low_start_reg) : int'(high_start_reg))
                        + int'($urandom_range(128)) - 64;
               end
               default:    value = $urandom_range(1) ? 65535 : 0;
            endcase
            if (value < 0) value = 0;
            if (value > 65535) value = 65535;
            level = wea_pkg::LEVEL_W'(value);
            send_level(level);
         end
      end
   endtask

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      averages_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_averages.size() == 0) begin
            $error("result transfer with no sample pending: low_average %0d high_average %0d",
                   rsp_low_average, rsp_high_average);
            error_count++;
         end else begin
            want = pending_averages.pop_front();
            checked_count++;
            if (rsp_low_average !== want.low_average) begin
               $error("low_average mismatch: expected %0d, actual %0d",
                      want.low_average, rsp_low_average);
               error_count++;
            end
            if (rsp_high_average !== want.high_average) begin
               $error("high_average mismatch: expected %0d, actual %0d",
                      want.high_average, rsp_high_average);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                     IDLE_LIMIT, pending_averages.size());
            $display("FAIL window_extreme_average_core");
            $finish;
         end
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_idle_pct = 30;
      recv_idle_pct = 70;
      test_unfilled_window();
      test_threshold_settings();
      test_random_traffic(30, 70, 140);
      test_random_traffic(70, 30, 140);
      test_random_traffic(0, 0, 140);
      drain_results();
      if (pending_averages.size() != 0) begin
         $error("%0d expected results never arrived", pending_averages.size());
         error_count++;
      end
      $display("covered %0d samples across %0d threshold settings and three flow profiles",
               levels_sent, setting_count);
      $display("%0d result transfers checked, %0d mismatches", checked_count, error_count);
      if (error_count == 0) begin
         $display("PASS window_extreme_average_core");
      end else begin
         $display("FAIL window_extreme_average_core");
      end
      $finish;
   end

endmodule

`default_nettype wire
